// ===== hw/rtl/prbt_pkg.sv =====
package prbt_pkg;

  localparam int MAX_NODES = 1024;
  localparam int MAX_LANES = 128;

  localparam int BYTE_W   = 8;
  localparam int NODE_W   = $clog2(MAX_NODES);
  localparam int NCNT_W   = NODE_W + 1;
  localparam int LANE_W   = $clog2(MAX_LANES);
  localparam int LCFG_W   = 8;
  localparam int ADDR_W   = NODE_W + LANE_W;
  localparam int STORE_DEPTH = MAX_NODES * MAX_LANES;

  localparam int Q_DEPTH  = 4;
  localparam int QPTR_W   = $clog2(Q_DEPTH);
  localparam int QCNT_W   = QPTR_W + 1;

  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_PARENT = 2'd1;
  localparam logic [1:0] ST_FULL   = 2'd2;

  localparam logic REG_LANES = 1'b0;
  localparam logic REG_MODE  = 1'b1;

  localparam logic [LCFG_W-1:0] LANES_RESET = LCFG_W'(MAX_LANES);

  typedef struct packed {
    logic [BYTE_W-1:0] in_byte;
    logic [1:0]        status;
    logic [NODE_W-1:0] node_index;
    logic [NODE_W-1:0] parent_node;
    logic [LANE_W-1:0] lane;
    logic              node_done;
    logic              use_parent;
    logic              wr_en;
  } req_t;

endpackage

// ===== hw/rtl/parent_residual_byte_transform_core.sv =====
// Parent residual byte transform.
// Input stream (s_*): one byte request per transfer. s_tdata holds in_byte,
// has_parent and parent_node; s_tuser flags the first byte of a set.
// Output stream (m_*): one result per request, same order. m_tdata holds
// out_byte, status and node_index; m_tlast marks the last lane of a node.
// APB port: lanes_per_node at 0x0, reconstruct_mode at 0x4; write only while
// the stream is idle.
// Throughput: one request per cycle sustained while m_tready is high. The limit
// is the node store, a simple dual-port RAM with one read (parent byte) and one
// write per request. A request passes the queue, back stage and m_tdata register.
// A four-entry request queue sits between the counter front and the store
// back, so s_tready drops only once m_tready has been low long enough to fill
// it; results hold on m_tdata while m_tready is low.
// Reset clears node and lane counters and the queue, sets lanes_per_node to
// 128 and reconstruct_mode to 1; store contents are undefined until written.
module parent_residual_byte_transform_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [23:0] s_tdata,   // in_byte[7:0], has_parent[8], parent_node[18:9]
  input  logic [0:0]  s_tuser,   // start_of_set[0]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [23:0] m_tdata,   // out_byte[7:0], status[9:8], node_index[19:10]
  output logic        m_tlast,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [prbt_pkg::LCFG_W-1:0] lanes_per_node;
  logic                        reconstruct_mode;
  logic                        cfg_wr;

  logic           q_push;
  logic           q_full;
  logic           q_pop;
  logic           q_nonempty;
  prbt_pkg::req_t q_req;
  prbt_pkg::req_t q_head;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      lanes_per_node   <= prbt_pkg::LANES_RESET;
      reconstruct_mode <= 1'b1;
    end else if (cfg_wr) begin
      unique case (paddr[2])
        prbt_pkg::REG_LANES: lanes_per_node   <= pwdata[prbt_pkg::LCFG_W-1:0];
        prbt_pkg::REG_MODE:  reconstruct_mode <= pwdata[0];
        default:             lanes_per_node   <= lanes_per_node;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      prbt_pkg::REG_LANES: prdata = 32'(lanes_per_node);
      prbt_pkg::REG_MODE:  prdata = 32'(reconstruct_mode);
      default:             prdata = '0;
    endcase
  end

  prbt_front u_front (
    .clk            (clk),
    .rst            (rst),
    .s_tvalid       (s_tvalid),
    .s_tready       (s_tready),
    .s_tdata        (s_tdata),
    .s_tuser        (s_tuser),
    .lanes_per_node (lanes_per_node),
    .q_full         (q_full),
    .q_push         (q_push),
    .q_req          (q_req)
  );

  prbt_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (q_push),
    .push_req (q_req),
    .full     (q_full),
    .pop      (q_pop),
    .nonempty (q_nonempty),
    .head     (q_head)
  );

  prbt_back u_back (
    .clk              (clk),
    .rst              (rst),
    .q_nonempty       (q_nonempty),
    .q_head           (q_head),
    .q_pop            (q_pop),
    .reconstruct_mode (reconstruct_mode),
    .m_tvalid         (m_tvalid),
    .m_tready         (m_tready),
    .m_tdata          (m_tdata),
    .m_tlast          (m_tlast)
  );

endmodule

// ===== hw/rtl/prbt_ram.sv =====
module prbt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // read returns the old contents on a same-address write
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== hw/rtl/prbt_front.sv =====
module prbt_front (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_tvalid,
  output logic                          s_tready,
  input  logic [23:0]                   s_tdata,
  input  logic [0:0]                    s_tuser,
  input  logic [prbt_pkg::LCFG_W-1:0]   lanes_per_node,
  input  logic                          q_full,
  output logic                          q_push,
  output prbt_pkg::req_t                q_req
);

  logic [prbt_pkg::NCNT_W-1:0] current_node;
  logic [prbt_pkg::LANE_W-1:0] current_lane;

  logic [prbt_pkg::NCNT_W-1:0] node;
  logic [prbt_pkg::LANE_W-1:0] lane;
  logic [prbt_pkg::LCFG_W-1:0] eff_lanes;
  logic [prbt_pkg::LCFG_W:0]   lane_p1;
  logic                        full;
  logic                        done;
  logic                        has_parent;
  logic [prbt_pkg::NODE_W-1:0] parent;
  logic                        parent_bad;

  assign s_tready   = !q_full;
  assign q_push     = s_tvalid && s_tready;
  assign has_parent = s_tdata[8];
  assign parent     = s_tdata[18:9];

  assign node = s_tuser[0] ? '0 : current_node;
  assign lane = s_tuser[0] ? '0 : current_lane;
  assign full = (node >= prbt_pkg::NCNT_W'(prbt_pkg::MAX_NODES));

  always_comb begin
    if (lanes_per_node == '0) begin
      eff_lanes = prbt_pkg::LCFG_W'(1);
    end else if (lanes_per_node > prbt_pkg::LANES_RESET) begin
      eff_lanes = prbt_pkg::LANES_RESET;
    end else begin
      eff_lanes = lanes_per_node;
    end
  end

  assign lane_p1    = (prbt_pkg::LCFG_W+1)'(lane) + (prbt_pkg::LCFG_W+1)'(1);
  assign done       = lane_p1 >= {1'b0, eff_lanes};
  assign parent_bad = has_parent && (prbt_pkg::NCNT_W'(parent) >= node);

  always_comb begin
    q_req             = '0;
    q_req.in_byte     = s_tdata[7:0];
    q_req.parent_node = parent;
    q_req.lane        = lane;
    q_req.node_done   = done;
    q_req.wr_en       = !full;
    q_req.node_index  = full ? '0 : node[prbt_pkg::NODE_W-1:0];
    q_req.use_parent  = !full && has_parent && !parent_bad;
    priority if (full) begin
      q_req.status = prbt_pkg::ST_FULL;
    end else if (parent_bad) begin
      q_req.status = prbt_pkg::ST_PARENT;
    end else begin
      q_req.status = prbt_pkg::ST_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      current_node <= '0;
      current_lane <= '0;
    end else if (q_push) begin
      if (done) begin
        current_lane <= '0;
        current_node <= full ? node : node + prbt_pkg::NCNT_W'(1);
      end else begin
        current_lane <= lane + prbt_pkg::LANE_W'(1);
        current_node <= node;
      end
    end
  end

endmodule

// ===== hw/rtl/prbt_queue.sv =====
module prbt_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  prbt_pkg::req_t push_req,
  output logic           full,
  input  logic           pop,
  output logic           nonempty,
  output prbt_pkg::req_t head
);

  prbt_pkg::req_t              slots [prbt_pkg::Q_DEPTH];
  logic [prbt_pkg::QPTR_W-1:0] wr_ptr;
  logic [prbt_pkg::QPTR_W-1:0] rd_ptr;
  logic [prbt_pkg::QCNT_W-1:0] count;

  assign full     = (count == prbt_pkg::QCNT_W'(prbt_pkg::Q_DEPTH));
  assign nonempty = (count != '0);
  assign head     = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_req;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + prbt_pkg::QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + prbt_pkg::QPTR_W'(1);
      end
      unique case ({push, pop})
        2'b10:   count <= count + prbt_pkg::QCNT_W'(1);
        2'b01:   count <= count - prbt_pkg::QCNT_W'(1);
        default: count <= count;
      endcase
    end
  end

endmodule

// ===== hw/rtl/prbt_back.sv =====
module prbt_back (
  input  logic           clk,
  input  logic           rst,
  input  logic           q_nonempty,
  input  prbt_pkg::req_t q_head,
  output logic           q_pop,
  input  logic           reconstruct_mode,
  output logic           m_tvalid,
  input  logic           m_tready,
  output logic [23:0]    m_tdata,
  output logic           m_tlast
);

  prbt_pkg::req_t              b1_req;
  logic                        b1_valid;
  logic                        b1_fresh;
  logic                        b1_fwd;
  logic [prbt_pkg::BYTE_W-1:0] b1_fwd_val;
  logic [prbt_pkg::BYTE_W-1:0] b1_hold;

  logic                        b1_move;
  logic                        wr_en;
  logic [prbt_pkg::ADDR_W-1:0] waddr;
  logic [prbt_pkg::ADDR_W-1:0] raddr;
  logic [prbt_pkg::BYTE_W-1:0] rdata;
  logic [prbt_pkg::BYTE_W-1:0] par_byte;
  logic [prbt_pkg::BYTE_W-1:0] result;
  logic [prbt_pkg::BYTE_W-1:0] store_val;
  logic                        fwd_hit;

  assign b1_move = b1_valid && (!m_tvalid || m_tready);
  assign q_pop   = q_nonempty && (!b1_valid || b1_move);
  assign wr_en   = b1_move && b1_req.wr_en;
  assign waddr   = {b1_req.node_index, b1_req.lane};
  assign raddr   = {q_head.parent_node, q_head.lane};
  assign fwd_hit = wr_en && (waddr == raddr);

  always_comb begin
    if (b1_fwd) begin
      par_byte = b1_fwd_val;
    end else if (b1_fresh) begin
      par_byte = rdata;
    end else begin
      par_byte = b1_hold;
    end
    if (!b1_req.use_parent) begin
      result = b1_req.in_byte;
    end else if (reconstruct_mode) begin
      result = b1_req.in_byte + par_byte;
    end else begin
      result = b1_req.in_byte - par_byte;
    end
    store_val = (b1_req.use_parent && reconstruct_mode) ? result : b1_req.in_byte;
  end

  prbt_ram #(
    .WIDTH (prbt_pkg::BYTE_W),
    .DEPTH (prbt_pkg::STORE_DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (wr_en),
    .waddr (waddr),
    .wdata (store_val),
    .re    (q_pop),
    .raddr (raddr),
    .rdata (rdata)
  );

  // read data shows in the cycle after the pop; keep it while the stage stalls
  always_ff @(posedge clk) begin
    if (rst) begin
      b1_valid <= 1'b0;
      b1_fresh <= 1'b0;
    end else if (q_pop) begin
      b1_valid <= 1'b1;
      b1_fresh <= 1'b1;
    end else begin
      b1_fresh <= 1'b0;
      if (b1_move) begin
        b1_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      b1_req     <= q_head;
      b1_fwd     <= fwd_hit;
      b1_fwd_val <= store_val;
    end else if (b1_fresh) begin
      b1_hold <= rdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (b1_move) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (b1_move) begin
      m_tdata <= {4'b0, b1_req.node_index, b1_req.status, result};
      m_tlast <= b1_req.node_done;
    end
  end

`ifndef NO_ASSERTIONS
  a_pop_fills_stage: assert property (@(posedge clk) disable iff (rst)
    q_pop |=> b1_valid)
    else $error("popped request did not reach the back stage");

  a_write_needs_stage: assert property (@(posedge clk) disable iff (rst)
    wr_en |-> (b1_valid && !(m_tvalid && !m_tready)))
    else $error("store written while the back stage is stalled");

  a_full_no_node: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tdata[9:8] == prbt_pkg::ST_FULL) |-> (m_tdata[19:10] == '0))
    else $error("store-full result carries a node index");

  a_fwd_from_write: assert property (@(posedge clk) disable iff (rst)
    (q_pop && fwd_hit) |-> b1_move)
    else $error("forwarding without a store write");
`endif

endmodule
